@@ sv/stream_substring_replace_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stream substring replace core
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STREAM_SUBSTRING_REPLACE_CORE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define SSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in a cycle implies the consequent in the next cycle.
`define SSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, register codes and types of the substring replace core.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int BYTE_W              = 8;
  localparam int ENTRY_BYTES         = 8;
  localparam int DATA_W              = ENTRY_BYTES * BYTE_W;
  localparam int LEN_W               = 4;
  localparam int IDX_W               = $clog2(ENTRY_BYTES);
  localparam int CFG_IDX_W           = 3;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3
  } cfg_reg_t;

  // Configuration as seen by the front end, lengths already clamped.
  typedef struct packed {
    logic [DATA_W-1:0] pattern;
    logic [LEN_W-1:0]  pattern_len;
    logic [DATA_W-1:0] repl;
    logic [LEN_W-1:0]  repl_len;
  } ssr_cfg_t;

  // One command for the output sequencer: emit cnt bytes of data, oldest in
  // the low bits. A zero count with last set is an end marker.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  cnt;
    logic              last;
  } ssr_cmd_t;

endpackage

@@ sv/ssr_front.sv @@
// ----------------------------------------------------------------------------
// ssr_front
// Window front end: takes one byte per cycle while the command queue has room,
// compares the window with the pattern and issues emit commands to that queue.
// ----------------------------------------------------------------------------
`include "stream_substring_replace_core_assert.svh"

module ssr_front
  import ssr_pkg::*;
#(
  parameter int WIN_DEPTH = DEF_MAX_PATTERN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  ssr_cfg_t          cfg,
  input  logic              win_clear,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ssr_cmd_t          cmd
);

  logic [BYTE_W-1:0] win_r   [WIN_DEPTH];
  logic [BYTE_W-1:0] win_nxt [WIN_DEPTH];
  logic [BYTE_W-1:0] win_ins [WIN_DEPTH];
  logic [LEN_W-1:0]  count_r, count_nxt, count_inc;
  logic              accept, full, match_ok;
  logic [DATA_W-1:0] flush_data;

  // A beat is taken whenever the queue has room for a command.
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && cmd_ready;
  assign count_inc = count_r + LEN_W'(1);
  assign full      = (count_inc == cfg.pattern_len);

  // Window with the new byte placed after the pending ones.
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_ins[i] = (count_r == LEN_W'(i)) ? in_byte : win_r[i];
    end
  end

  // Parallel compare of the window against the pattern.
  always_comb begin
    match_ok = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((LEN_W'(i) < cfg.pattern_len) &&
          (win_ins[i] != cfg.pattern[i*BYTE_W +: BYTE_W])) begin
        match_ok = 1'b0;
      end
    end
  end

  // Pending bytes packed oldest first for a flush.
  always_comb begin
    flush_data = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      flush_data[i*BYTE_W +: BYTE_W] = win_ins[i];
    end
  end

  // Classify the beat and choose the command and the next window.
  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '0;
    count_nxt = count_r;
    win_nxt   = win_r;
    if (accept) begin
      win_nxt   = win_ins;
      count_nxt = count_inc;
      if (full && match_ok) begin
        count_nxt = '0;
        if ((cfg.repl_len != '0) || in_last) begin
          cmd_valid = 1'b1;
          cmd.data  = cfg.repl;
          cmd.cnt   = cfg.repl_len;
          cmd.last  = in_last;
        end
      end else if (in_last) begin
        count_nxt = '0;
        cmd_valid = 1'b1;
        cmd.data  = flush_data;
        cmd.cnt   = count_inc;
        cmd.last  = 1'b1;
      end else if (full) begin
        cmd_valid = 1'b1;
        cmd.data  = DATA_W'(win_ins[0]);
        cmd.cnt   = LEN_W'(1);
        cmd.last  = 1'b0;
        count_nxt = count_r;
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_ins[i+1];
        end
      end
    end
    if (win_clear) begin
      count_nxt = '0;
    end
  end

  // Window bytes need no reset; the fill count does.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `SSR_ASSERT(a_front_count_below_depth, clk, rst_n, count_r < LEN_W'(WIN_DEPTH), "window count reached the window depth")
  `SSR_ASSERT_NEXT(a_front_last_empties, clk, rst_n, accept && in_last, count_r == '0, "window not empty after the last beat")

endmodule

@@ sv/ssr_queue.sv @@
// ----------------------------------------------------------------------------
// ssr_queue
// Short command queue that decouples the window front end from the output
// sequencer.
// ----------------------------------------------------------------------------
`include "stream_substring_replace_core_assert.svh"

module ssr_queue
  import ssr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  ssr_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output ssr_cmd_t pop_cmd
);

  ssr_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  `SSR_ASSERT(a_queue_count_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `SSR_ASSERT(a_queue_no_overflow, clk, rst_n, !(push_valid && !push_ready), "command dropped on a full queue")

endmodule

@@ sv/ssr_back.sv @@
// ----------------------------------------------------------------------------
// ssr_back
// Output sequencer: walks the head command one byte per beat into the
// registered result stage.
// ----------------------------------------------------------------------------
`include "stream_substring_replace_core_assert.svh"

module ssr_back
  import ssr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  ssr_cmd_t          pop_cmd,
  output logic              out_beat_valid,
  input  logic              out_beat_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_valid,
  output logic              out_last
);

  logic [IDX_W-1:0]  idx_r;
  logic              obv_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              ovalid_r, olast_r;
  logic              adv, gen, final_byte;

  // The result register can load when empty or when its beat leaves.
  assign adv        = !obv_r || out_beat_ready;
  assign gen        = pop_valid && adv;
  assign final_byte = ((LEN_W'(idx_r) + LEN_W'(1)) >= pop_cmd.cnt);
  assign pop_ready  = adv && final_byte;

  // Byte index within the head command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      obv_r <= 1'b0;
    end else begin
      if (gen) begin
        idx_r <= final_byte ? '0 : idx_r + IDX_W'(1);
      end
      if (adv) begin
        obv_r <= gen;
      end
    end
  end

  // Result payload; a zero-count command gives the end marker.
  always_ff @(posedge clk) begin
    if (gen) begin
      obyte_r  <= (pop_cmd.cnt == '0) ? '0 : pop_cmd.data[idx_r*BYTE_W +: BYTE_W];
      ovalid_r <= (pop_cmd.cnt != '0);
      olast_r  <= pop_cmd.last && final_byte;
    end
  end

  assign out_beat_valid = obv_r;
  assign out_byte       = obyte_r;
  assign out_valid      = ovalid_r;
  assign out_last       = olast_r;

  `SSR_ASSERT(a_back_marker_is_last, clk, rst_n, !(obv_r && !ovalid_r) || olast_r, "end marker without last flag")
  `SSR_ASSERT(a_back_idx_in_cmd, clk, rst_n, !(pop_valid && (idx_r != '0)) || (LEN_W'(idx_r) < pop_cmd.cnt), "byte index beyond head command")

endmodule

@@ sv/stream_substring_replace_core.sv @@
// ----------------------------------------------------------------------------
// stream_substring_replace_core
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement string.
// ----------------------------------------------------------------------------
// The core takes one input byte per cycle while its queue has room and gives
// one result byte per cycle while the receiver takes them. A beat enters the
// window front end, where the window is compared with the pattern in parallel,
// and the command (one byte, a replacement, or a final flush) goes through a
// four-entry queue to the output sequencer, which sends one byte per cycle.
// A result is registered in the queue, then in the sequencer's result stage.
// Input keeps its rate as long as the output keeps up; a match with an R-byte
// replacement, or a final flush of W bytes, holds the sequencer while it sends
// them, and input stalls only once the queue is full. The configuration port
// is always ready; writing pattern_length discards the pending window bytes.
// ----------------------------------------------------------------------------
module stream_substring_replace_core
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_last,
  output logic                 out_beat_valid,
  input  logic                 out_beat_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_valid,
  output logic                 out_last
);

  localparam int WIN_DEPTH = (MAX_PATTERN < ENTRY_BYTES) ? MAX_PATTERN : ENTRY_BYTES;
  localparam int REP_DEPTH = (MAX_REPLACEMENT < ENTRY_BYTES) ? MAX_REPLACEMENT : ENTRY_BYTES;

  logic [DATA_W-1:0] pattern_r, repl_r;
  logic [LEN_W-1:0]  plen_r, rlen_r;
  logic              cfg_wr, win_clear;
  ssr_cfg_t          cfg;
  logic              q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  ssr_cmd_t          q_push_cmd, q_pop_cmd;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign win_clear = cfg_wr && (cfg_reg_t'(cfg_index) == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= LEN_W'(1);
      repl_r    <= '0;
      rlen_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_r <= cfg_data;
        REG_PATTERN_LENGTH:     plen_r    <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  repl_r    <= cfg_data;
        REG_REPLACEMENT_LENGTH: rlen_r    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the lengths to what the window and replacement paths hold.
  always_comb begin
    cfg.pattern = pattern_r;
    cfg.repl    = repl_r;
    if (plen_r == '0) begin
      cfg.pattern_len = LEN_W'(1);
    end else if (plen_r > LEN_W'(WIN_DEPTH)) begin
      cfg.pattern_len = LEN_W'(WIN_DEPTH);
    end else begin
      cfg.pattern_len = plen_r;
    end
    cfg.repl_len = (rlen_r > LEN_W'(REP_DEPTH)) ? LEN_W'(REP_DEPTH) : rlen_r;
  end

  ssr_front #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg       (cfg),
    .win_clear (win_clear),
    .cmd_valid (q_push_valid),
    .cmd_ready (q_push_ready),
    .cmd       (q_push_cmd)
  );

  ssr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  ssr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (q_pop_valid),
    .pop_ready      (q_pop_ready),
    .pop_cmd        (q_pop_cmd),
    .out_beat_valid (out_beat_valid),
    .out_beat_ready (out_beat_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

endmodule
